// File: sv/neighbor_cache_oldest_replace_unit_defines.svh
// Assertion macros shared by the neighbor cache RTL.
`ifndef NEIGHBOR_CACHE_OLDEST_REPLACE_UNIT_DEFINES_SVH
`define NEIGHBOR_CACHE_OLDEST_REPLACE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define NCOR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("neighbor cache assertion failed");
// next-cycle implication
`define NCOR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("neighbor cache assertion failed");
`else
`define NCOR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NCOR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/ncor_pkg.sv
// Types and constants of the neighbor cache.
package ncor_pkg;

	localparam int ENTRIES_DEF = 8;

	localparam int IP_W    = 64;
	localparam int MAC_W   = 48;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 3;
	localparam int WORD_W  = 2 * IP_W + MAC_W + STAMP_W;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_SAVE   = 1'b1;

	localparam logic [1:0] ACT_LOOKUP  = 2'd0;
	localparam logic [1:0] ACT_REFRESH = 2'd1;
	localparam logic [1:0] ACT_FILL    = 2'd2;
	localparam logic [1:0] ACT_REPLACE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// File: sv/ncor_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ncor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/neighbor_cache_oldest_replace_unit.sv
// Neighbor cache top level: sequencer, entry scan and result registers.
// Flow: an accepted item runs through the scan, drain and finish states; done is registered
// from finish, high once back in idle. Busy stays high from scan to finish; idle takes the
// next start, so a new item is taken only once the last is through. The scan reads one
// entry a cycle from the single RAM read port. No result stall.
// Reset clears all valid bits and the sequencer; the entry RAM is not cleared.
`include "neighbor_cache_oldest_replace_unit_defines.svh"

module neighbor_cache_oldest_replace_unit #(
	parameter int ENTRIES = ncor_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [ncor_pkg::IP_W-1:0]     ip_hi,
	input  logic [ncor_pkg::IP_W-1:0]     ip_lo,
	input  logic [ncor_pkg::MAC_W-1:0]    mac_in,
	input  logic [ncor_pkg::STAMP_W-1:0]  now_ms,
	output logic                          done,
	output logic                          hit,
	output logic [ncor_pkg::MAC_W-1:0]    mac_out,
	output logic [ncor_pkg::SLOT_W-1:0]   slot,
	output logic [1:0]                    action
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam int IP_W    = ncor_pkg::IP_W;
	localparam int MAC_W   = ncor_pkg::MAC_W;
	localparam int STAMP_W = ncor_pkg::STAMP_W;
	localparam int SLOT_W  = ncor_pkg::SLOT_W;
	localparam int WORD_W  = ncor_pkg::WORD_W;

	// Sequencer state
	ncor_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;

	// Latched item
	logic               cmd_q;
	logic [IP_W-1:0]    ip_hi_q, ip_lo_q;
	logic [MAC_W-1:0]   mac_q;
	logic [STAMP_W-1:0] now_q;

	// Valid bit per entry, in flops so reset empties the table at once
	logic [ENTRIES-1:0] valid_q;

	// Scan trackers
	logic               match_found_q, free_found_q;
	logic [IDX_W-1:0]   match_idx_q, free_idx_q, oldest_idx_q;
	logic [MAC_W-1:0]   match_mac_q;
	logic [STAMP_W-1:0] min_stamp_q;

	// Read pipeline
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	// RAM port signals
	logic               rd_en, wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]  wr_data, rd_data;

	// Result registers
	logic               done_q, hit_q;
	logic [MAC_W-1:0]   mac_out_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [1:0]         action_q;

	// Combinational result of the finish step
	logic               res_hit;
	logic [MAC_W-1:0]   res_mac;
	logic [IDX_W-1:0]   res_idx;
	logic [1:0]         res_action;
	logic [IDX_W+SLOT_W-1:0] res_idx_ext;

	// Fields of the entry returning from the RAM
	logic [IP_W-1:0]    rd_ip_hi, rd_ip_lo;
	logic [MAC_W-1:0]   rd_mac;
	logic [STAMP_W-1:0] rd_stamp;
	logic               ent_match, ent_free, ent_older;

	logic accept;

	assign accept = start && (state_q == ncor_pkg::ST_IDLE);
	assign busy   = (state_q != ncor_pkg::ST_IDLE);

	assign {rd_ip_hi, rd_ip_lo, rd_mac, rd_stamp} = rd_data;

	// Entry RAM: {ip_hi, ip_lo, mac, stamp}
	ncor_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ncor_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ncor_pkg::ST_SCAN;
				end
			end
			ncor_pkg::ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ncor_pkg::ST_DRAIN;
				end
			end
			ncor_pkg::ST_DRAIN: begin
				state_d = ncor_pkg::ST_FINISH;
			end
			ncor_pkg::ST_FINISH: begin
				state_d = ncor_pkg::ST_IDLE;
			end
			default: begin
				state_d = ncor_pkg::ST_IDLE;
			end
		endcase
	end

	// Judge the entry coming back from the RAM
	always_comb begin
		ent_match = rd_vld_s1 && valid_q[idx_s1]
			&& (rd_ip_hi == ip_hi_q) && (rd_ip_lo == ip_lo_q);
		ent_free  = rd_vld_s1 && !valid_q[idx_s1];
		// first entry seeds the minimum; strict less keeps the lowest index on a tie
		ent_older = rd_vld_s1 && ((idx_s1 == '0) || (rd_stamp < min_stamp_q));
	end

	// Outputs of the sequencer: RAM control and the finish decision
	always_comb begin
		rd_en      = (state_q == ncor_pkg::ST_SCAN);
		wr_en      = 1'b0;
		wr_addr    = oldest_idx_q;
		wr_data    = {ip_hi_q, ip_lo_q, mac_q, now_q};
		res_hit    = 1'b0;
		res_mac    = '0;
		res_idx    = '0;
		res_action = ncor_pkg::ACT_LOOKUP;
		if (state_q == ncor_pkg::ST_FINISH) begin
			if (cmd_q == ncor_pkg::CMD_LOOKUP) begin
				if (match_found_q) begin
					res_hit = 1'b1;
					res_mac = match_mac_q;
					res_idx = match_idx_q;
				end
			end else if (match_found_q) begin
				// refresh the stamp, keep the stored MAC
				wr_en      = 1'b1;
				wr_addr    = match_idx_q;
				wr_data    = {ip_hi_q, ip_lo_q, match_mac_q, now_q};
				res_hit    = 1'b1;
				res_idx    = match_idx_q;
				res_action = ncor_pkg::ACT_REFRESH;
			end else if (free_found_q) begin
				wr_en      = 1'b1;
				wr_addr    = free_idx_q;
				res_idx    = free_idx_q;
				res_action = ncor_pkg::ACT_FILL;
			end else begin
				// table full: evict the oldest entry
				wr_en      = 1'b1;
				wr_addr    = oldest_idx_q;
				res_idx    = oldest_idx_q;
				res_action = ncor_pkg::ACT_REPLACE;
			end
		end
	end

	// Report the index modulo eight
	assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ncor_pkg::ST_IDLE;
			cnt_q         <= '0;
			valid_q       <= '0;
			rd_vld_s1     <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == ncor_pkg::ST_FINISH);
			if (accept) begin
				cnt_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (rd_en && (cnt_q != LAST_IDX)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (ent_match && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (ent_free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Payload registers: latched item, trackers, result
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			cmd_q   <= cmd;
			ip_hi_q <= ip_hi;
			ip_lo_q <= ip_lo;
			mac_q   <= mac_in;
			now_q   <= now_ms;
		end
		if (ent_match && !match_found_q) begin
			match_idx_q <= idx_s1;
			match_mac_q <= rd_mac;
		end
		if (ent_free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (ent_older) begin
			min_stamp_q  <= rd_stamp;
			oldest_idx_q <= idx_s1;
		end
		if (state_q == ncor_pkg::ST_FINISH) begin
			hit_q     <= res_hit;
			mac_out_q <= res_mac;
			slot_q    <= res_idx_ext[SLOT_W-1:0];
			action_q  <= res_action;
		end
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign mac_out = mac_out_q;
	assign slot    = slot_q;
	assign action  = action_q;

	`NCOR_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == ncor_pkg::ST_IDLE)
	`NCOR_ASSERT_NXT(a_accept_scan, clk, arst_n, accept, state_q == ncor_pkg::ST_SCAN)
	`NCOR_ASSERT_NXT(a_finish_done, clk, arst_n, state_q == ncor_pkg::ST_FINISH, done_q)
	`NCOR_ASSERT_IMP(a_refresh_hit, clk, arst_n, done_q && (action_q == ncor_pkg::ACT_REFRESH), hit_q)

endmodule

// File: verif/neighbor_cache_oldest_replace_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the neighbor cache: directed and random lookups and saves.
module neighbor_cache_oldest_replace_unit_tb;

	localparam int ENTRIES      = ncor_pkg::ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 1300;
	localparam int POOL_SIZE    = 12;
	localparam int TAIL_CYCLES  = 3 * (ENTRIES + 3);
	localparam int LIMIT_CYCLES = 200000;
	localparam int REPORT_MAX   = 10;

	// one item as the sender presents it, plus pacing hints for the driver
	typedef struct packed {
		logic                         cmd;
		logic [ncor_pkg::IP_W-1:0]    hi;
		logic [ncor_pkg::IP_W-1:0]    lo;
		logic [ncor_pkg::MAC_W-1:0]   mac;
		logic [ncor_pkg::STAMP_W-1:0] now;
		logic [1:0]                   phase;
		logic                         drain;
	} cache_item_t;

	typedef struct packed {
		logic                        hit;
		logic [ncor_pkg::MAC_W-1:0]  mac;
		logic [ncor_pkg::SLOT_W-1:0] slot;
		logic [1:0]                  action;
	} cache_result_t;

	logic                          clk     = 1'b0;
	logic                          arst_n  = 1'b0;
	logic                          start   = 1'b0;
	logic                          cmd     = ncor_pkg::CMD_LOOKUP;
	logic [ncor_pkg::IP_W-1:0]     ip_hi   = '0;
	logic [ncor_pkg::IP_W-1:0]     ip_lo   = '0;
	logic [ncor_pkg::MAC_W-1:0]    mac_in  = '0;
	logic [ncor_pkg::STAMP_W-1:0]  now_ms  = '0;
	logic                          busy;
	logic                          done;
	logic                          hit;
	logic [ncor_pkg::MAC_W-1:0]    mac_out;
	logic [ncor_pkg::SLOT_W-1:0]   slot;
	logic [1:0]                    action;

	neighbor_cache_oldest_replace_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.ip_hi   (ip_hi),
		.ip_lo   (ip_lo),
		.mac_in  (mac_in),
		.now_ms  (now_ms),
		.done    (done),
		.hit     (hit),
		.mac_out (mac_out),
		.slot    (slot),
		.action  (action)
	);

	// shadow copy of the table
	logic                         shadow_valid [ENTRIES];
	logic [ncor_pkg::IP_W-1:0]    shadow_hi    [ENTRIES];
	logic [ncor_pkg::IP_W-1:0]    shadow_lo    [ENTRIES];
	logic [ncor_pkg::MAC_W-1:0]   shadow_mac   [ENTRIES];
	logic [ncor_pkg::STAMP_W-1:0] shadow_stamp [ENTRIES];

	cache_item_t   pending_items[$];
	cache_result_t expected_results[$];

	logic [ncor_pkg::IP_W-1:0]    pool_hi [POOL_SIZE];
	logic [ncor_pkg::IP_W-1:0]    pool_lo [POOL_SIZE];
	logic [ncor_pkg::STAMP_W-1:0] clock_ms = '0;

	logic item_taken = 1'b0;
	int   mismatches = 0;
	int   cycles     = 0;
	int   n_hits = 0, n_misses = 0, n_refresh = 0, n_fill = 0, n_replace = 0;

	// free-running clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// expected outcome of one item; updates the shadow table on a save
	function automatic cache_result_t cache_predict(cache_item_t it);
		cache_result_t r;
		int            m;
		int            fr;
		int            old;
		r   = '0;
		m   = -1;
		fr  = -1;
		old = 0;
		// first valid entry with the same address wins
		for (int k = 0; k < ENTRIES; k++) begin
			if (m < 0 && shadow_valid[k] && shadow_hi[k] == it.hi && shadow_lo[k] == it.lo)
				m = k;
		end
		if (it.cmd == ncor_pkg::CMD_LOOKUP) begin
			r.action = ncor_pkg::ACT_LOOKUP;
			if (m >= 0) begin
				r.hit  = 1'b1;
				r.mac  = shadow_mac[m];
				r.slot = m[ncor_pkg::SLOT_W-1:0];
			end
		end else if (m >= 0) begin
			// refresh keeps the stored MAC
			shadow_stamp[m] = it.now;
			r.hit    = 1'b1;
			r.slot   = m[ncor_pkg::SLOT_W-1:0];
			r.action = ncor_pkg::ACT_REFRESH;
		end else begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (fr < 0 && !shadow_valid[k])
					fr = k;
			end
			if (fr >= 0) begin
				r.action = ncor_pkg::ACT_FILL;
			end else begin
				// strict compare keeps the lowest index on equal stamps
				for (int k = 1; k < ENTRIES; k++) begin
					if (shadow_stamp[k] < shadow_stamp[old])
						old = k;
				end
				fr       = old;
				r.action = ncor_pkg::ACT_REPLACE;
			end
			shadow_valid[fr] = 1'b1;
			shadow_hi[fr]    = it.hi;
			shadow_lo[fr]    = it.lo;
			shadow_mac[fr]   = it.mac;
			shadow_stamp[fr] = it.now;
			r.slot           = fr[ncor_pkg::SLOT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int idle_percent(logic [1:0] phase);
		case (phase)
			2'd0: return 12;
			2'd1: return 49;
			default: return 0;
		endcase
	endfunction

	function automatic void queue_item(logic c, logic [63:0] h, logic [63:0] l,
		logic [47:0] m, logic [31:0] t, logic [1:0] ph, logic dr);
		cache_item_t it;
		it.cmd   = c;
		it.hi    = h;
		it.lo    = l;
		it.mac   = m;
		it.now   = t;
		it.phase = ph;
		it.drain = dr;
		pending_items.push_back(it);
	endfunction

	// random item: mostly pool addresses so the table fills, hits and ages
	function automatic void queue_random(logic [1:0] ph, logic dr);
		logic [63:0] h;
		logic [63:0] l;
		logic [31:0] t;
		int          sel;
		int          pick;
		sel  = $urandom_range(99);
		pick = $urandom_range(POOL_SIZE - 1);
		h    = pool_hi[pick];
		l    = pool_lo[pick];
		if (sel >= 85) begin
			h = rand64();
			l = rand64();
		end else if (sel >= 70) begin
			// near miss: one bit off in one half
			if ($urandom_range(1))
				h[6'($urandom_range(63))] ^= 1'b1;
			else
				l[6'($urandom_range(63))] ^= 1'b1;
		end
		// advance the clock slowly so equal stamps are common
		sel = $urandom_range(99);
		if (sel < 10)
			t = $urandom;
		else if (sel < 13)
			t = '0;
		else if (sel < 16)
			t = '1;
		else begin
			clock_ms = clock_ms + $urandom_range(3);
			t        = clock_ms;
		end
		queue_item(1'($urandom_range(1)), h, l, 48'({$urandom, $urandom}), t, ph, dr);
	endfunction

	// hold reset, then release it on a falling edge
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// mark the item accepted at this edge for the driver
	always @(posedge clk) begin
		item_taken <= arst_n && start && !busy;
	end

	// driver: present the next item on the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!start || item_taken)) begin
			if (pending_items.size() != 0
				&& !(pending_items[0].drain && expected_results.size() != 0)
				&& $urandom_range(99) >= idle_percent(pending_items[0].phase)) begin
				start  <= 1'b1;
				cmd    <= pending_items[0].cmd;
				ip_hi  <= pending_items[0].hi;
				ip_lo  <= pending_items[0].lo;
				mac_in <= pending_items[0].mac;
				now_ms <= pending_items[0].now;
				void'(pending_items.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check each strobed result, then predict the item accepted at this edge
	cache_result_t seen;
	cache_result_t want;
	cache_item_t   taken;
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				seen = '{hit, mac_out, slot, action};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0t] unexpected result: hit %b mac %h slot %0d action %0d",
							$time, seen.hit, seen.mac, seen.slot, seen.action);
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("[%0t] mismatch: hit %b/%b mac %h/%h slot %0d/%0d action %0d/%0d (exp/act)",
								$time, want.hit, seen.hit, want.mac, seen.mac,
								want.slot, seen.slot, want.action, seen.action);
					end
				end
			end
			if (start && !busy) begin
				taken = '{cmd, ip_hi, ip_lo, mac_in, now_ms, 2'd0, 1'b0};
				want  = cache_predict(taken);
				expected_results.push_back(want);
				case (want.action)
					ncor_pkg::ACT_LOOKUP: if (want.hit) n_hits++; else n_misses++;
					ncor_pkg::ACT_REFRESH: n_refresh++;
					ncor_pkg::ACT_FILL: n_fill++;
					default: n_replace++;
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	logic [63:0] a_hi;
	initial begin
		for (int k = 0; k < ENTRIES; k++)
			shadow_valid[k] = 1'b0;
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++) begin
			pool_hi[k] = rand64();
			pool_lo[k] = rand64();
		end

		// directed: empty table, extremes, equal stamps, refresh, replacement
		a_hi = 64'h0123_4567_89ab_cdef;
		queue_item(ncor_pkg::CMD_LOOKUP, '0, '0, '1, '1, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '1, '1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, '0, '0, '1, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, '1, '1, '0, '1, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '0, '0, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '1, '1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '0, 64'd1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, 64'd1, '0, 48'ha5a5_a5a5_a5a5, 32'd5, 2'd0, 1'b0);
		for (int k = 0; k < 5; k++)
			queue_item(ncor_pkg::CMD_SAVE, a_hi, 64'(k), 48'(k + 16), 32'd5, 2'd0, 1'b0);
		// table full: oldest is slot 0, then equal stamps pick the lowest index
		queue_item(ncor_pkg::CMD_SAVE, a_hi, 64'd100, 48'h5a5a_5a5a_5a5a, 32'd100, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, a_hi, 64'd101, 48'h1234_5678_9abc, 32'd100, 2'd0, 1'b0);
		// refresh keeps the old MAC, then gets replaced as the oldest
		queue_item(ncor_pkg::CMD_SAVE, '1, '1, 48'hffff_0000_ffff, 32'd3, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '1, '1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, a_hi, 64'd102, 48'h0f0f_0f0f_0f0f, 32'd7, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '1, '1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, '0, '0, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_LOOKUP, a_hi, 64'd1, '0, '0, 2'd0, 1'b0);
		queue_item(ncor_pkg::CMD_SAVE, a_hi, 64'd1, 48'h0, 32'd9, 2'd0, 1'b1);

		// random: three pacing phases, with a full drain at each phase start and at every 200th item from item 100
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_random(2'((i * 3) / RANDOM_ITEMS),
				((i * 3) % RANDOM_ITEMS) < 3 || (i % 200) == 100);

		// wait for the queue to empty, the results to arrive, then a quiet tail
		do
			@(posedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			mismatches += expected_results.size();
			$display("%0d expected results never arrived", expected_results.size());
		end
		$display("covered %0d lookup hits, %0d misses, %0d refreshes, %0d fills, %0d replacements",
			n_hits, n_misses, n_refresh, n_fill, n_replace);
		$display("in %0d cycles under three pacing phases; %0d mismatches", cycles, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
